>>> rtl/core/rvdf_pkg.sv
// Shared types and constants for the recent-value duplicate filter.
// No dependencies; used by the cell, the hit reducer and the top level.
package rvdf_pkg;

  localparam int DATA_W  = 32;  // width of one stored value
  localparam int GROUP_W = 32;  // match bits folded per reducer group
  localparam int OUT_W   = 8;   // result tdata, padded to a whole byte

  // Per-item sequence through the cell row.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_FIN
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;    // register this cell's match against the candidate
    logic shift;  // take the neighbor's value (cell 0 takes the candidate)
  } cell_ctrl_t;

endpackage

>>> rtl/core/rvdf_cell.sv
// One entry of the recent-value window: holds a value, compares it with the
// candidate and passes it on to the next cell on an insert. Uses rvdf_pkg.
module rvdf_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rvdf_pkg::cell_ctrl_t       ctrl,
  input  logic [rvdf_pkg::DATA_W-1:0] cand,
  input  logic [rvdf_pkg::DATA_W-1:0] prev_val,
  output logic [rvdf_pkg::DATA_W-1:0] val_r,
  output logic                       match_r
);

  // Entries reset to zero, so zero counts as seen until pushed out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (ctrl.shift) begin
      val_r <= prev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match_r <= (val_r == cand);
    end
  end

endmodule

>>> rtl/core/rvdf_hit_reduce.sv
// OR of all cell match bits: each group of GROUP_W folded into a registered flag,
// then the group flags folded combinationally into one hit. Uses rvdf_pkg.
module rvdf_hit_reduce #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] match,
  output logic             hit
);

  localparam int NGRP  = (DEPTH + rvdf_pkg::GROUP_W - 1) / rvdf_pkg::GROUP_W;
  localparam int PAD_W = NGRP * rvdf_pkg::GROUP_W;

  logic [PAD_W-1:0] match_pad;
  logic [NGRP-1:0]  grp_r;

  assign match_pad = PAD_W'(match);

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= |match_pad[g*rvdf_pkg::GROUP_W +: rvdf_pkg::GROUP_W];
    end
  end

  assign hit = |grp_r;

endmodule

>>> rtl/core/recent_value_duplicate_filter.sv
// Recent-value duplicate filter: a row of WINDOW_DEPTH cells, newest first.
// Result registered through the compare, group fold, then final fold with
// commit, held back only while the output is stalled. One item in flight: a
// new item is taken only after the compare/fold/commit sequence over the cell
// row ends. Reset: synchronous, all cells zero, no clearing pass. Depends on
// rvdf_pkg, rvdf_cell, rvdf_hit_reduce.
module recent_value_duplicate_filter #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rvdf_pkg::DATA_W-1:0] in_tdata,   // [31:0] candidate
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rvdf_pkg::OUT_W-1:0]  out_tdata   // [0] is_unique, [7:1] zero
);

  rvdf_pkg::state_t        state_r, state_nxt;
  rvdf_pkg::cell_ctrl_t    ctrl;
  logic [rvdf_pkg::DATA_W-1:0] cand_r;
  logic [rvdf_pkg::DATA_W-1:0] cell_val [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]     cell_match;
  logic                        hit;
  logic                        commit;
  logic                        out_valid_r;
  logic                        out_unique_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rvdf_pkg::ST_IDLE: if (in_tvalid) state_nxt = rvdf_pkg::ST_CMP;
      rvdf_pkg::ST_CMP:  state_nxt = rvdf_pkg::ST_RED;
      rvdf_pkg::ST_RED:  state_nxt = rvdf_pkg::ST_FIN;
      rvdf_pkg::ST_FIN:  if (!out_valid_r || out_tready) state_nxt = rvdf_pkg::ST_IDLE;
      default:           state_nxt = rvdf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    commit     = 1'b0;
    ctrl.cmp   = 1'b0;
    ctrl.shift = 1'b0;
    unique case (state_r)
      rvdf_pkg::ST_IDLE: in_tready = 1'b1;
      rvdf_pkg::ST_CMP:  ctrl.cmp = 1'b1;
      rvdf_pkg::ST_RED:  ;
      rvdf_pkg::ST_FIN: begin
        commit     = !out_valid_r || out_tready;
        ctrl.shift = commit && !hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvdf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cand_r <= in_tdata;
    end
  end

  // Cell row: on an insert every value moves one cell down, the oldest drops.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [rvdf_pkg::DATA_W-1:0] prev_val;
    if (i == 0) begin : g_head
      assign prev_val = cand_r;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
    end
    rvdf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cand     (cand_r),
      .prev_val (prev_val),
      .val_r    (cell_val[i]),
      .match_r  (cell_match[i])
    );
  end

  rvdf_hit_reduce #(
    .DEPTH (WINDOW_DEPTH)
  ) u_reduce (
    .clk   (clk),
    .match (cell_match),
    .hit   (hit)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_unique_r <= !hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rvdf_pkg::OUT_W-1){1'b0}}, out_unique_r};

endmodule

>>> rtl/core/rvdf_checker.sv
// Port-level checks for recent_value_duplicate_filter, attached by bind.
// Uses rvdf_pkg for the port widths.
module rvdf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rvdf_pkg::OUT_W-1:0]  out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // One item in flight: busy for the whole compare sequence.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input taken during compare sequence");

  // A new result only appears at the end of a sequence.
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without an item in flight");

  // Result padding above is_unique stays zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("result padding bits not zero");

endmodule

bind recent_value_duplicate_filter rvdf_checker u_rvdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
